// ----- src/sha_pkg.sv -----
// Shared types and constants for the SHA-256 byte stream hasher.
package sha_pkg;

    // Queue beat from the byte collector to the compression engine:
    // one 512-bit block plus a flag that asks for the digest afterwards.
    typedef struct packed {
        logic [511:0] block;
        logic         final_blk;
    } blk_beat_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_POS = 56;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- src/sha_front.sv -----
// Front end: gathers message bytes into blocks and builds the padding blocks.
module sha_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            s_data_byte,
    input  logic                  s_has_byte,
    input  logic                  s_last,
    input  logic                  s_valid,
    output logic                  s_ready,
    output sha_pkg::blk_beat_t    q_data,
    output logic                  q_valid,
    input  logic                  q_ready
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        F_COLLECT = 3'b001,
        F_PAD1    = 3'b010,
        F_PAD2    = 3'b100
    } fstate_t;

    fstate_t      state_reg, state_next;
    logic [511:0] buf_reg, buf_next;
    logic [60:0]  count_reg, count_next;
    logic         q_valid_reg, q_valid_next;
    blk_beat_t    q_data_reg, q_data_next;
    logic [5:0]   idx;
    logic         q_free;
    logic [63:0]  bit_len;

    assign q_free  = !q_valid_reg || q_ready;
    assign s_ready = (state_reg == F_COLLECT) && q_free;
    assign q_valid = q_valid_reg;
    assign q_data  = q_data_reg;
    assign bit_len = {count_reg, 3'b000};
    assign idx     = count_reg[5:0];

    // Byte collection, padding and block hand-off
    always_comb begin
        logic [511:0] b;
        logic [5:0]   pi;
        b            = buf_reg;
        pi           = idx;
        state_next   = state_reg;
        count_next   = count_reg;
        q_valid_next = q_valid_reg && !q_ready;
        q_data_next  = q_data_reg;
        buf_next     = buf_reg;
        unique case (state_reg)
            F_COLLECT: begin
                if (s_valid && s_ready) begin
                    if (s_has_byte) begin
                        b[511 - 8*idx -: 8] = s_data_byte;
                        count_next = count_reg + 61'd1;
                        pi         = idx + 6'd1;
                    end
                    if (s_has_byte && pi == 6'd0) begin
                        q_valid_next = 1'b1;
                        q_data_next  = '{block: b, final_blk: 1'b0};
                    end
                    buf_next = b;
                    if (s_last) state_next = F_PAD1;
                end
            end
            F_PAD1: begin
                // first padding block; may be the final one
                if (q_free) begin
                    b[511 - 8*idx -: 8] = PAD_BYTE;
                    for (int i = 0; i < 64; i++)
                        if (i > int'(idx)) b[511 - 8*i -: 8] = 8'h00;
                    q_valid_next = 1'b1;
                    if (idx < 6'(LEN_POS)) begin
                        b[63:0]     = bit_len;
                        q_data_next = '{block: b, final_blk: 1'b1};
                        count_next  = '0;
                        state_next  = F_COLLECT;
                    end else begin
                        q_data_next = '{block: b, final_blk: 1'b0};
                        state_next  = F_PAD2;
                    end
                end
            end
            F_PAD2: begin
                if (q_free) begin
                    q_valid_next = 1'b1;
                    q_data_next  = '{block: {448'd0, bit_len}, final_blk: 1'b1};
                    count_next   = '0;
                    state_next   = F_COLLECT;
                end
            end
            default: state_next = F_COLLECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_COLLECT;
            count_reg   <= '0;
            q_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            q_valid_reg <= q_valid_next;
        end
        buf_reg    <= buf_next;
        q_data_reg <= q_data_next;
    end

endmodule

// ----- src/sha_queue.sv -----
// Two-entry block queue between front end and compression engine.
module sha_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  sha_pkg::blk_beat_t in_data,
    input  logic               in_valid,
    output logic               in_ready,
    output sha_pkg::blk_beat_t out_data,
    output logic               out_valid,
    input  logic               out_ready
);
    import sha_pkg::*;

    blk_beat_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wp_reg] <= in_data;
    end

endmodule

// ----- src/sha_engine.sv -----
// Back end: 64-round compression, one round per cycle, and digest output.
module sha_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  sha_pkg::blk_beat_t q_data,
    input  logic               q_valid,
    output logic               q_ready,
    output logic [31:0]        m_digest_word,
    output logic [2:0]         m_word_index,
    output logic               m_last_word,
    output logic               m_valid,
    input  logic               m_ready
);
    import sha_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE  = 4'b0001,
        E_ROUND = 4'b0010,
        E_ADD   = 4'b0100,
        E_OUT   = 4'b1000
    } estate_t;

    estate_t     state_reg, state_next;
    logic [31:0] chain_reg [8];
    logic [31:0] wv_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  rnd_reg;
    logic        fin_reg;
    logic [2:0]  oidx_reg;
    logic        m_valid_reg;
    logic [31:0] wt, w_new, s1, s0, chv, mj, t1, t2, sg0, sg1;

    // message schedule: window shifts, new word enters at the top
    assign sg1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign sg0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign w_new = sg1 + w_reg[9] + sg0 + w_reg[0];
    assign wt    = w_reg[0];

    // round function
    assign s1  = rotr(wv_reg[4], 6) ^ rotr(wv_reg[4], 11) ^ rotr(wv_reg[4], 25);
    assign chv = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
    assign t1  = wv_reg[7] + s1 + chv + ROUND_K[rnd_reg] + wt;
    assign s0  = rotr(wv_reg[0], 2) ^ rotr(wv_reg[0], 13) ^ rotr(wv_reg[0], 22);
    assign mj  = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
    assign t2  = s0 + mj;

    assign q_ready       = state_reg == E_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_digest_word = chain_reg[oidx_reg];
    assign m_word_index  = oidx_reg;
    assign m_last_word   = oidx_reg == 3'd7;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            E_IDLE:  if (q_valid) state_next = E_ROUND;
            E_ROUND: if (rnd_reg == 6'd63) state_next = E_ADD;
            E_ADD:   state_next = fin_reg ? E_OUT : E_IDLE;
            E_OUT:   if (m_ready && oidx_reg == 3'd7) state_next = E_IDLE;
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            rnd_reg     <= '0;
            oidx_reg    <= '0;
            m_valid_reg <= 1'b0;
            fin_reg     <= 1'b0;
            for (int i = 0; i < 8; i++) chain_reg[i] <= INIT_HASH[i];
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                E_IDLE: begin
                    rnd_reg <= '0;
                    if (q_valid) fin_reg <= q_data.final_blk;
                end
                E_ROUND: rnd_reg <= rnd_reg + 6'd1;
                E_ADD: begin
                    for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + wv_reg[i];
                    m_valid_reg <= fin_reg;
                    oidx_reg    <= '0;
                end
                E_OUT: begin
                    if (m_ready) begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7) begin
                            m_valid_reg <= 1'b0;
                            for (int i = 0; i < 8; i++) chain_reg[i] <= INIT_HASH[i];
                        end
                    end
                end
                default: ;
            endcase
        end
        // datapath registers
        if (state_reg == E_IDLE && q_valid) begin
            for (int i = 0; i < 16; i++) w_reg[i] <= q_data.block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) wv_reg[i] <= chain_reg[i];
        end else if (state_reg == E_ROUND) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
    end

endmodule

// ----- src/sha256_byte_stream_hasher_core.sv -----
// Top level of the SHA-256 byte stream hasher.
//  channel | direction | fields                               | handshake
//  s_      | in        | data_byte[8], has_byte, last         | s_valid/s_ready
//  m_      | out       | digest_word[32], word_index[3], last_word | m_valid/m_ready
// Bytes enter one per cycle while s_ready is high; a full block goes to a
// two-entry queue and the engine compresses it: a load, 64 rounds (one per cycle)
// and an add, so the sustained rate is set by the round loop.
// A last beat costs one or two padding blocks and eight digest beats.
// Reset (aresetn low, synchronous) loads the initial hash and clears all control.
// Either side may stall; the queue holds finished blocks meanwhile.
module sha256_byte_stream_hasher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_last,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word,
    output logic        m_valid,
    input  logic        m_ready
);
    import sha_pkg::*;

    blk_beat_t fq_data, qe_data;
    logic      fq_valid, fq_ready, qe_valid, qe_ready;

    sha_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_data_byte(s_data_byte), .s_has_byte(s_has_byte), .s_last(s_last),
        .s_valid(s_valid), .s_ready(s_ready),
        .q_data(fq_data), .q_valid(fq_valid), .q_ready(fq_ready)
    );

    sha_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_data(fq_data), .in_valid(fq_valid), .in_ready(fq_ready),
        .out_data(qe_data), .out_valid(qe_valid), .out_ready(qe_ready)
    );

    sha_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .q_data(qe_data), .q_valid(qe_valid), .q_ready(qe_ready),
        .m_digest_word(m_digest_word), .m_word_index(m_word_index),
        .m_last_word(m_last_word), .m_valid(m_valid), .m_ready(m_ready)
    );

endmodule

// ----- src/sha_checker.sv -----
// Port-level checks for the SHA-256 hasher, bound to the top level.
module sha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_digest_word,
    input logic [2:0]  m_word_index,
    input logic        m_last_word
);
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digest_word) && $stable(m_word_index))
        else $error("result changed while stalled");

    // last_word marks index seven only
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_word == (m_word_index == 3'd7)))
        else $error("last_word out of place");

    // words follow in order within a digest
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_word |=> m_valid && m_word_index == $past(m_word_index) + 3'd1)
        else $error("digest word order broken");

    // a digest starts at word zero
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> m_word_index == 3'd0)
        else $error("digest did not start at word zero");
endmodule

bind sha256_byte_stream_hasher_core sha_checker u_sha_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_digest_word(m_digest_word), .m_word_index(m_word_index),
    .m_last_word(m_last_word)
);

// ----- sim/sha256_digest_checker.sv -----
// Watches both channels of the hasher, computes expected digests and compares them.
module sha256_digest_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_last,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] m_digest_word,
    input  logic [2:0]  m_word_index,
    input  logic        m_last_word,
    input  logic        m_valid,
    input  logic        m_ready,
    output int          fail_count,
    output int          words_pending
);
    import sha_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last_word;
    } digest_beat_t;

    digest_beat_t digest_q[$];

    logic [31:0] chain_words [8];
    logic [7:0]  msg_block [64];
    logic [60:0] msg_bytes;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of msg_block into chain_words.
    task automatic compress_msg_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1, sg0, sg1;
        int slot;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 0; i < 8; i++) v[i] = chain_words[i];
        for (int r = 0; r < 64; r++) begin
            slot = r & 15;
            if (r >= 16) begin
                sg1 = ror32(w[(r-2)&15], 17) ^ ror32(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
                sg0 = ror32(w[(r-15)&15], 7) ^ ror32(w[(r-15)&15], 18)
                    ^ (w[(r-15)&15] >> 3);
                w[slot] = sg1 + w[(r-7)&15] + sg0 + w[slot];
            end
            s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
            t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[slot];
            s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
            t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_words[i] = chain_words[i] + v[i];
    endtask

    // Absorb one input beat; on end of message pad and queue the digest.
    task automatic absorb_beat(input logic [7:0] b, input logic hb, input logic lst);
        int idx;
        logic [63:0] bit_len;
        digest_beat_t d;
        if (hb) begin
            msg_block[msg_bytes[5:0]] = b;
            msg_bytes = msg_bytes + 61'd1;
            if (msg_bytes[5:0] == 6'd0) compress_msg_block();
        end
        if (lst) begin
            idx = int'(msg_bytes[5:0]);
            msg_block[idx] = PAD_BYTE;
            idx++;
            if (idx > LEN_POS) begin
                while (idx < 64) begin msg_block[idx] = 8'h00; idx++; end
                compress_msg_block();
                idx = 0;
            end
            while (idx < LEN_POS) begin msg_block[idx] = 8'h00; idx++; end
            bit_len = {msg_bytes, 3'b000};
            for (int i = 0; i < 8; i++) msg_block[LEN_POS + i] = bit_len[63 - 8*i -: 8];
            compress_msg_block();
            for (int i = 0; i < 8; i++) begin
                d.word = chain_words[i];
                d.index = i[2:0];
                d.last_word = (i == 7);
                digest_q = {digest_q, d};
            end
            for (int i = 0; i < 8; i++) chain_words[i] = INIT_HASH[i];
            msg_bytes = '0;
        end
    endtask

    // Monitor both channels at each edge.
    always @(posedge aclk) begin
        digest_beat_t exp_beat;
        if (!aresetn) begin
            digest_q.delete();
            for (int i = 0; i < 8; i++) chain_words[i] = INIT_HASH[i];
            msg_bytes = '0;
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    $error("digest beat with nothing expected: word %h", m_digest_word);
                    fail_count++;
                end else begin
                    exp_beat = digest_q.pop_front();
                    if (m_digest_word !== exp_beat.word) begin
                        $error("digest_word expected %h actual %h", exp_beat.word,
                               m_digest_word);
                        fail_count++;
                    end
                    if (m_word_index !== exp_beat.index) begin
                        $error("word_index expected %0d actual %0d", exp_beat.index,
                               m_word_index);
                        fail_count++;
                    end
                    if (m_last_word !== exp_beat.last_word) begin
                        $error("last_word expected %0b actual %0b", exp_beat.last_word,
                               m_last_word);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) absorb_beat(s_data_byte, s_has_byte, s_last);
        end
        words_pending = digest_q.size();
    end

endmodule

// ----- sim/tb_sha256_byte_stream_hasher_core.sv -----
// Testbench top: drives byte-stream messages into the hasher and reports the verdict.
module tb_sha256_byte_stream_hasher_core;

    logic        aclk;
    logic        aresetn;
    logic [7:0]  s_data_byte;
    logic        s_has_byte;
    logic        s_last;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;
    logic        m_valid;
    logic        m_ready;
    int          fail_count;
    int          words_pending;
    int          cycle_count = 0;
    int          beats_sent;

    localparam int CYCLE_LIMIT = 400000;

    sha256_byte_stream_hasher_core u_dut (.*);

    sha256_digest_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog on total cycles.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stall per digest beat, with stretches of none.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            repeat (stall) @(posedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
            m_ready <= 1'b0;
        end
    end

    // One input beat, preceded by the given idle gap.
    task automatic send_beat(input logic [7:0] b, input logic hb, input logic lst,
                             input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data_byte <= b;
        s_has_byte  <= hb;
        s_last      <= lst;
        s_valid     <= 1'b1;
        @(posedge aclk iff s_ready);
        beats_sent++;
    endtask

    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
    endfunction

    // Message of n bytes, random or all equal to v, with occasional idle beats inside.
    task automatic send_message(input int n, input bit fixed_val, input logic [7:0] v);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0, draw_gap());
            send_beat(fixed_val ? v : 8'($urandom), 1'b1, (i == n - 1), draw_gap());
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_has_byte  = 1'b0;
        s_last      = 1'b0;
        beats_sent  = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty message, idle beat, byte extremes, short messages.
        send_beat(8'h00, 1'b0, 1'b1, 0);
        send_beat(8'hff, 1'b0, 1'b0, 0);
        send_beat(8'h00, 1'b0, 1'b1, 3);
        send_beat(8'hff, 1'b1, 1'b1, 0);
        send_beat(8'h00, 1'b1, 1'b1, 0);
        send_message(3, 1'b1, 8'haa);
        send_message(2, 1'b1, 8'h55);
        send_beat(8'h61, 1'b1, 1'b0, 0);
        send_beat(8'h62, 1'b0, 1'b1, 0);

        // Let every digest drain before continuing.
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (words_pending == 0);
        @(posedge aclk);

        // Lengths around the one- and two-block padding boundaries.
        send_message(55, 1'b0, 8'h00);
        send_message(56, 1'b0, 8'h00);
        send_message(63, 1'b0, 8'h00);
        send_message(64, 1'b0, 8'h00);

        // Random messages, mostly short, some multi-block.
        while (beats_sent < 280) begin
            if ($urandom_range(0, 9) == 0)
                send_message($urandom_range(65, 140), 1'b0, 8'h00);
            else
                send_message($urandom_range(1, 20), 1'b0, 8'h00);
            if ($urandom_range(0, 7) == 0)
                send_beat(8'($urandom), 1'b0, 1'b1, draw_gap());
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        wait (words_pending == 0);
        repeat (300) @(posedge aclk);
        if (fail_count == 0 && words_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
